### rtl/core/gbpe_pkg.sv
// gbpe_pkg: shared types and constants of the glyph bitmap pixel expander
// used by every module under rtl/core, depends on nothing
`timescale 1ns / 1ps

package gbpe_pkg;

    localparam int BYTE_BITS  = 8;
    localparam int PIX_CNT_W  = 4;
    localparam int DIM_W      = 6;
    localparam int COLOR_W    = 24;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_GLYPH_WIDTH  = 2'd0,
        REG_GLYPH_HEIGHT = 2'd1,
        REG_FORE_COLOR   = 2'd2,
        REG_BACK_COLOR   = 2'd3
    } reg_idx_t;

    typedef enum logic {
        CTRL_IDLE,
        CTRL_BUSY
    } ctrl_state_t;

    typedef struct packed {
        logic [DIM_W-1:0]   glyph_width;
        logic [DIM_W-1:0]   glyph_height;
        logic [COLOR_W-1:0] fore_color;
        logic [COLOR_W-1:0] back_color;
    } cfg_t;

    typedef struct packed {
        logic                 load;
        logic [BYTE_BITS-1:0] bits;
        logic [PIX_CNT_W-1:0] count;
        logic                 glyph_end;
    } load_t;

    typedef struct packed {
        logic busy;
        logic step;
        logic last;
    } ser_stat_t;

endpackage

### rtl/core/gbpe_cfg_regs.sv
// gbpe_cfg_regs: apb register file holding glyph size and colors
// depends on gbpe_pkg
`timescale 1ns / 1ps

module gbpe_cfg_regs
    import gbpe_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_GLYPH_WIDTH:  cfg_next.glyph_width  = pwdata[DIM_W-1:0];
                REG_GLYPH_HEIGHT: cfg_next.glyph_height = pwdata[DIM_W-1:0];
                REG_FORE_COLOR:   cfg_next.fore_color   = pwdata[COLOR_W-1:0];
                REG_BACK_COLOR:   cfg_next.back_color   = pwdata[COLOR_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_GLYPH_WIDTH:  prdata = APB_DATA_W'(cfg_reg.glyph_width);
            REG_GLYPH_HEIGHT: prdata = APB_DATA_W'(cfg_reg.glyph_height);
            REG_FORE_COLOR:   prdata = APB_DATA_W'(cfg_reg.fore_color);
            REG_BACK_COLOR:   prdata = APB_DATA_W'(cfg_reg.back_color);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.glyph_width  <= DIM_W'(16);
            cfg_reg.glyph_height <= DIM_W'(16);
            cfg_reg.fore_color   <= 24'hFFFFFF;
            cfg_reg.back_color   <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/core/gbpe_glyph_ctrl.sv
// gbpe_glyph_ctrl: byte sequencer tracking row, remaining pixels and cursor
// depends on gbpe_pkg, drives gbpe_bit_serializer through load_t
`timescale 1ns / 1ps

module gbpe_glyph_ctrl
    import gbpe_pkg::*;
#(
    parameter int COORD_BITS     = 12,
    parameter int MAX_GLYPH_SIDE = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfg_t                  cfg,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_BITS-1:0]  font_byte,
    input  logic                  start_glyph,
    input  logic [COORD_BITS-1:0] origin_x,
    input  logic [COORD_BITS-1:0] origin_y,
    input  ser_stat_t             ser_stat,
    output load_t                 load,
    output logic [COORD_BITS-1:0] cursor_x,
    output logic [COORD_BITS-1:0] cursor_y
);

    localparam int SW = $clog2(MAX_GLYPH_SIDE + 1);

    ctrl_state_t           state_reg, state_next;
    logic [SW-1:0]         rem_reg, rem_next;
    logic [SW-1:0]         row_idx_reg, row_idx_next;
    logic [COORD_BITS-1:0] cursor_x_reg, cursor_x_next;
    logic [COORD_BITS-1:0] cursor_y_reg, cursor_y_next;
    logic [COORD_BITS-1:0] left_x_reg, left_x_next;
    logic                  row_end_reg, row_end_next;
    logic                  glyph_end_reg, glyph_end_next;

    logic [SW-1:0]         eff_w;
    logic [SW-1:0]         eff_h;
    logic [SW-1:0]         rem_cur;
    logic [SW-1:0]         ridx_cur;
    logic [SW-1:0]         rem_after;
    logic [PIX_CNT_W-1:0]  n_pix;
    logic                  row_end;
    logic                  glyph_end;

    assign s_tready = (state_reg == CTRL_IDLE);
    assign cursor_x = cursor_x_reg;
    assign cursor_y = cursor_y_reg;

    // clamp the programmed size to the supported side; a zero height counts as one
    always_comb begin
        if (int'(cfg.glyph_width) > MAX_GLYPH_SIDE) begin
            eff_w = SW'(MAX_GLYPH_SIDE);
        end else begin
            eff_w = SW'(cfg.glyph_width);
        end
        if (cfg.glyph_height == '0) begin
            eff_h = SW'(1);
        end else if (int'(cfg.glyph_height) > MAX_GLYPH_SIDE) begin
            eff_h = SW'(MAX_GLYPH_SIDE);
        end else begin
            eff_h = SW'(cfg.glyph_height);
        end
    end

    always_comb begin
        rem_cur  = start_glyph ? eff_w : rem_reg;
        ridx_cur = start_glyph ? '0 : row_idx_reg;
        if (int'(rem_cur) >= BYTE_BITS) begin
            n_pix = PIX_CNT_W'(BYTE_BITS);
        end else begin
            n_pix = rem_cur[PIX_CNT_W-1:0];
        end
        rem_after = rem_cur - SW'(n_pix);
        row_end   = (rem_after == '0);
        glyph_end = row_end && ((int'(ridx_cur) + 1) >= int'(eff_h));
    end

    always_comb begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        row_idx_next   = row_idx_reg;
        cursor_x_next  = cursor_x_reg;
        cursor_y_next  = cursor_y_reg;
        left_x_next    = left_x_reg;
        row_end_next   = row_end_reg;
        glyph_end_next = glyph_end_reg;
        load.load      = 1'b0;
        load.bits      = font_byte;
        load.count     = n_pix;
        load.glyph_end = glyph_end;

        case (state_reg)
            CTRL_IDLE: begin
                if (s_tvalid) begin
                    if (start_glyph) begin
                        left_x_next   = origin_x;
                        cursor_x_next = origin_x;
                        cursor_y_next = origin_y;
                        row_idx_next  = '0;
                    end
                    rem_next       = rem_after;
                    row_end_next   = row_end;
                    glyph_end_next = glyph_end;
                    if (n_pix != '0) begin
                        load.load  = 1'b1;
                        state_next = CTRL_BUSY;
                    end
                end
            end
            CTRL_BUSY: begin
                if (ser_stat.step) begin
                    cursor_x_next = cursor_x_reg + COORD_BITS'(1);
                    if (ser_stat.last) begin
                        state_next = CTRL_IDLE;
                        if (row_end_reg) begin
                            if (glyph_end_reg) begin
                                rem_next     = '0;
                                row_idx_next = '0;
                            end else begin
                                row_idx_next  = row_idx_reg + SW'(1);
                                cursor_y_next = cursor_y_reg + COORD_BITS'(1);
                                cursor_x_next = left_x_reg;
                                rem_next      = eff_w;
                            end
                        end
                    end
                end
            end
            default: begin
                state_next = CTRL_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= CTRL_IDLE;
            rem_reg       <= '0;
            row_idx_reg   <= '0;
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
            left_x_reg    <= '0;
            row_end_reg   <= 1'b0;
            glyph_end_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rem_reg       <= rem_next;
            row_idx_reg   <= row_idx_next;
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            left_x_reg    <= left_x_next;
            row_end_reg   <= row_end_next;
            glyph_end_reg <= glyph_end_next;
        end
    end

endmodule

### rtl/core/gbpe_bit_serializer.sv
// gbpe_bit_serializer: shifts a font byte out msb first, one pixel per cycle
// while m_ is not stalled, into the output register; depends on gbpe_pkg
`timescale 1ns / 1ps

module gbpe_bit_serializer
    import gbpe_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfg_t                  cfg,
    input  load_t                 load,
    input  logic [COORD_BITS-1:0] cursor_x,
    input  logic [COORD_BITS-1:0] cursor_y,
    output ser_stat_t             ser_stat,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic [COLOR_W-1:0]    pixel_color,
    output logic                  last_of_byte,
    output logic                  glyph_done
);

    logic [BYTE_BITS-1:0]  shift_reg, shift_next;
    logic [PIX_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  gend_reg, gend_next;
    logic                  active_reg, active_next;
    logic                  valid_reg, valid_next;
    logic [COORD_BITS-1:0] px_reg, px_next;
    logic [COORD_BITS-1:0] py_reg, py_next;
    logic [COLOR_W-1:0]    color_reg, color_next;
    logic                  lob_reg, lob_next;
    logic                  done_reg, done_next;
    logic                  step;
    logic                  last;

    assign step = active_reg && (!valid_reg || m_tready);
    assign last = (cnt_reg == PIX_CNT_W'(1));

    assign ser_stat.busy = active_reg;
    assign ser_stat.step = step;
    assign ser_stat.last = last;

    assign m_tvalid     = valid_reg;
    assign pixel_x      = px_reg;
    assign pixel_y      = py_reg;
    assign pixel_color  = color_reg;
    assign last_of_byte = lob_reg;
    assign glyph_done   = done_reg;

    always_comb begin
        shift_next  = shift_reg;
        cnt_next    = cnt_reg;
        gend_next   = gend_reg;
        active_next = active_reg;
        valid_next  = valid_reg && !m_tready;
        px_next     = px_reg;
        py_next     = py_reg;
        color_next  = color_reg;
        lob_next    = lob_reg;
        done_next   = done_reg;

        if (load.load) begin
            shift_next  = load.bits;
            cnt_next    = load.count;
            gend_next   = load.glyph_end;
            active_next = 1'b1;
        end else if (step) begin
            valid_next  = 1'b1;
            px_next     = cursor_x;
            py_next     = cursor_y;
            color_next  = shift_reg[BYTE_BITS-1] ? cfg.fore_color : cfg.back_color;
            lob_next    = last;
            done_next   = last && gend_reg;
            shift_next  = {shift_reg[BYTE_BITS-2:0], 1'b0};
            cnt_next    = cnt_reg - PIX_CNT_W'(1);
            active_next = !last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        gend_reg  <= gend_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        color_reg <= color_next;
        lob_reg   <= lob_next;
        done_reg  <= done_next;
    end

endmodule

### rtl/core/glyph_bitmap_pixel_expander.sv
// glyph_bitmap_pixel_expander: top level, expands font bytes into pixel writes
// depends on gbpe_pkg, gbpe_cfg_regs, gbpe_glyph_ctrl, gbpe_bit_serializer
//
//  channel  direction  transaction            sideband
//  s_       in         one font byte          tuser = start_glyph
//  m_       out        one pixel write        tlast = last_of_byte, tuser = glyph_done
//  apb      in         register write / read  pready tied high
//
// a byte is accepted, then its n = 1..8 pixels are shifted out; the bit serializer
// emits one pixel a cycle while m_ is not stalled
// a byte that yields no pixel is accepted without loading the serializer
// reset is synchronous and active low; registers return to width 16,
// height 16, white foreground, black background
// a stall on m_ holds the serializer; the next byte is taken while the last
// pixel still waits in the output register
`timescale 1ns / 1ps

module glyph_bitmap_pixel_expander
    import gbpe_pkg::*;
#(
    parameter int COORD_BITS     = 12,
    parameter int MAX_GLYPH_SIDE = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // font_byte, origin_x, origin_y, zero fill
    input  logic [((BYTE_BITS + 2 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // start_glyph
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // pixel_x, pixel_y, pixel_color, zero fill
    output logic [((2 * COORD_BITS + COLOR_W + 7) / 8) * 8 - 1:0] m_tdata,
    output logic                  m_tlast,
    // glyph_done
    output logic                  m_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int M_TDATA_W = ((2 * COORD_BITS + COLOR_W + 7) / 8) * 8;

    cfg_t                  cfg;
    load_t                 load;
    ser_stat_t             ser_stat;
    logic [COORD_BITS-1:0] cursor_x;
    logic [COORD_BITS-1:0] cursor_y;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_W-1:0]    pixel_color;

    gbpe_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gbpe_glyph_ctrl #(
        .COORD_BITS     (COORD_BITS),
        .MAX_GLYPH_SIDE (MAX_GLYPH_SIDE)
    ) u_glyph_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .font_byte   (s_tdata[BYTE_BITS-1:0]),
        .start_glyph (s_tuser),
        .origin_x    (s_tdata[BYTE_BITS +: COORD_BITS]),
        .origin_y    (s_tdata[BYTE_BITS + COORD_BITS +: COORD_BITS]),
        .ser_stat    (ser_stat),
        .load        (load),
        .cursor_x    (cursor_x),
        .cursor_y    (cursor_y)
    );

    gbpe_bit_serializer #(
        .COORD_BITS (COORD_BITS)
    ) u_bit_serializer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .load         (load),
        .cursor_x     (cursor_x),
        .cursor_y     (cursor_y),
        .ser_stat     (ser_stat),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_color  (pixel_color),
        .last_of_byte (m_tlast),
        .glyph_done   (m_tuser)
    );

    assign m_tdata = M_TDATA_W'({pixel_color, pixel_y, pixel_x});

    // glyph end is only flagged on the closing pixel of a byte
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("glyph_done without last_of_byte");

    // a byte is never taken while the serializer still holds pixels
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> !ser_stat.busy)
        else $error("byte accepted while serializer busy");

    // the sequencer is ready again right after the last pixel leaves the shifter
    a_ready_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        ser_stat.step && ser_stat.last |=> s_tready && !ser_stat.busy)
        else $error("sequencer not idle after last pixel");

    // a load starts the serializer and takes the sequencer out of idle
    a_load_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        load.load |=> ser_stat.busy && !s_tready)
        else $error("load did not start the serializer");

endmodule

### tb/sv/glyph_bitmap_pixel_expander_tb.sv
// glyph_bitmap_pixel_expander_tb: self-checking bench that streams font bytes,
// predicts every pixel write and compares it field by field against m_ output
// depends on gbpe_pkg and glyph_bitmap_pixel_expander
`timescale 1ns / 1ps

module glyph_bitmap_pixel_expander_tb;
    import gbpe_pkg::*;

    localparam int COORD_W      = 12;
    localparam int MAX_SIDE     = 32;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] color;
        logic               last;
        logic               done;
    } pixel_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    // font_byte, origin_x, origin_y
    logic [31:0]           s_tdata;
    // start_glyph
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // pixel_x, pixel_y, pixel_color
    logic [47:0]           m_tdata;
    logic                  m_tlast;
    // glyph_done
    logic                  m_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // predictor copy of registers and glyph walk
    logic [DIM_W-1:0]   cfg_width;
    logic [DIM_W-1:0]   cfg_height;
    logic [COLOR_W-1:0] cfg_fore;
    logic [COLOR_W-1:0] cfg_back;
    int                 rows_left;
    int                 row_num;
    logic [COORD_W-1:0] cur_x;
    logic [COORD_W-1:0] cur_y;
    logic [COORD_W-1:0] org_x;

    pixel_t pixel_q[$];
    pixel_t want_px;

    int src_idle_pct;
    int sink_stall_pct;
    int mismatches;
    int bytes_sent;
    int drawing_bytes;
    int pixels_seen;
    int reg_writes;
    int cycles;

    glyph_bitmap_pixel_expander u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pixels outstanding", cycles, pixel_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int eff_width();
        if (cfg_width > MAX_SIDE) return MAX_SIDE;
        return int'(cfg_width);
    endfunction

    function automatic int eff_height();
        if (cfg_height == 0) return 1;
        if (cfg_height > MAX_SIDE) return MAX_SIDE;
        return int'(cfg_height);
    endfunction

    function automatic int glyph_bytes();
        if (eff_width() == 0) return 1;
        return eff_height() * ((eff_width() + 7) / 8);
    endfunction

    function automatic void expand_byte(input logic [7:0] font_bits, input logic first,
                                        input logic [COORD_W-1:0] ox,
                                        input logic [COORD_W-1:0] oy);
        int     count;
        logic   row_end;
        logic   glyph_end;
        pixel_t px;
        if (first) begin
            org_x     = ox;
            cur_x     = ox;
            cur_y     = oy;
            row_num   = 0;
            rows_left = eff_width();
        end
        if (rows_left == 0) return;
        count     = (rows_left < 8) ? rows_left : 8;
        rows_left = rows_left - count;
        row_end   = (rows_left == 0);
        glyph_end = row_end && (row_num + 1 >= eff_height());
        drawing_bytes++;
        for (int k = 0; k < count; k++) begin
            px.x     = cur_x;
            px.y     = cur_y;
            px.color = font_bits[7] ? cfg_fore : cfg_back;
            px.last  = (k == count - 1);
            px.done  = px.last && glyph_end;
            pixel_q.push_back(px);
            font_bits = font_bits << 1;
            cur_x     = cur_x + 1'b1;
        end
        if (row_end) begin
            if (glyph_end) begin
                rows_left = 0;
                row_num   = 0;
            end else begin
                row_num   = (row_num + 1) % 64;
                cur_y     = cur_y + 1'b1;
                cur_x     = org_x;
                rows_left = eff_width();
            end
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            pixels_seen++;
            if (pixel_q.size() == 0) begin
                $error("pixel transaction with none expected: x=0x%0h y=0x%0h",
                       m_tdata[11:0], m_tdata[23:12]);
                mismatches++;
            end else begin
                want_px = pixel_q.pop_front();
                check_field("pixel_x", 32'(want_px.x), 32'(m_tdata[11:0]));
                check_field("pixel_y", 32'(want_px.y), 32'(m_tdata[23:12]));
                check_field("pixel_color", 32'(want_px.color), 32'(m_tdata[47:24]));
                check_field("last_of_byte", 32'(want_px.last), 32'(m_tlast));
                check_field("glyph_done", 32'(want_px.done), 32'(m_tuser));
            end
        end
    end

    task automatic send_byte(input logic [7:0] font_bits, input logic first,
                             input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] oy);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {oy, ox, font_bits};
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        expand_byte(font_bits, first, ox, oy);
    endtask

    // block idle: no byte in flight and every pixel drained
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        quiesce();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_writes++;
        case (idx)
            REG_GLYPH_WIDTH:  cfg_width  = value[DIM_W-1:0];
            REG_GLYPH_HEIGHT: cfg_height = value[DIM_W-1:0];
            REG_FORE_COLOR:   cfg_fore   = value[COLOR_W-1:0];
            REG_BACK_COLOR:   cfg_back   = value[COLOR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic randomize_config(input bit all_regs);
        int h;
        int w;
        int pick;
        if (all_regs || $urandom_range(1)) begin
            pick = $urandom_range(99);
            if (pick < 80) h = $urandom_range(1, 6);
            else if (pick < 90) h = 0;
            else h = $urandom_range(20, 63);
            pick = $urandom_range(99);
            if (h > 8) w = $urandom_range(1, 8);
            else if (pick < 70) w = $urandom_range(1, 24);
            else if (pick < 80) w = 0;
            else if (pick < 90) w = $urandom_range(25, 32);
            else w = $urandom_range(33, 63);
            reg_write(REG_GLYPH_WIDTH, w);
            reg_write(REG_GLYPH_HEIGHT, h);
        end
        if (all_regs || $urandom_range(1))
            reg_write(REG_FORE_COLOR, ($urandom_range(9) == 0) ? 32'h0 : $urandom());
        if (all_regs || $urandom_range(1))
            reg_write(REG_BACK_COLOR, ($urandom_range(9) == 0) ? 32'hFFFFFF : $urandom());
    endtask

    task automatic test_stray_and_wrap();
        send_byte(8'hFF, 1'b0, 12'h000, 12'h000);
        send_byte(8'hA5, 1'b1, 12'hFFF, 12'hFFF);
        send_byte(8'hFF, 1'b0, 12'h123, 12'h456);
        send_byte(8'h00, 1'b0, 12'h000, 12'h000);
        send_byte(8'h3C, 1'b1, 12'h000, 12'h7FF);
        quiesce();
    endtask

    task automatic test_degenerate_sizes();
        reg_write(REG_GLYPH_WIDTH, 0);
        send_byte(8'hFF, 1'b1, 12'h010, 12'h020);
        send_byte(8'h81, 1'b0, 12'h000, 12'h000);
        reg_write(REG_GLYPH_WIDTH, 63);
        reg_write(REG_GLYPH_HEIGHT, 0);
        reg_write(REG_FORE_COLOR, 32'h0);
        reg_write(REG_BACK_COLOR, 32'hFFFFFF);
        send_byte(8'h80, 1'b1, 12'hFF0, 12'h800);
        send_byte(8'h01, 1'b0, 12'h000, 12'h000);
        send_byte(8'hFF, 1'b0, 12'h000, 12'h000);
        send_byte(8'h00, 1'b0, 12'h000, 12'h000);
        send_byte(8'hAA, 1'b0, 12'h000, 12'h000);
        quiesce();
    endtask

    task automatic test_row_tails();
        reg_write(REG_GLYPH_WIDTH, 8);
        reg_write(REG_GLYPH_HEIGHT, 1);
        send_byte(8'h81, 1'b1, 12'h100, 12'h200);
        reg_write(REG_GLYPH_WIDTH, 9);
        send_byte(8'h55, 1'b1, 12'hFFC, 12'h001);
        send_byte(8'h80, 1'b0, 12'h000, 12'h000);
        reg_write(REG_GLYPH_WIDTH, 3);
        reg_write(REG_GLYPH_HEIGHT, 2);
        send_byte(8'hE0, 1'b1, 12'h005, 12'hFFF);
        send_byte(8'h5F, 1'b0, 12'h000, 12'h000);
        quiesce();
    endtask

    task automatic test_midglyph_reconfig();
        reg_write(REG_GLYPH_WIDTH, 12);
        reg_write(REG_GLYPH_HEIGHT, 4);
        send_byte(8'hF0, 1'b1, 12'h040, 12'h050);
        reg_write(REG_GLYPH_WIDTH, 5);
        reg_write(REG_FORE_COLOR, 32'h123456);
        reg_write(REG_BACK_COLOR, 32'hABCDEF);
        send_byte(8'hC3, 1'b0, 12'h000, 12'h000);
        send_byte(8'hA8, 1'b0, 12'h000, 12'h000);
        // zero width ends the glyph after this row, no glyph_done
        reg_write(REG_GLYPH_WIDTH, 0);
        send_byte(8'h70, 1'b0, 12'h000, 12'h000);
        send_byte(8'hFF, 1'b0, 12'h000, 12'h000);
        // lower height takes effect at the next row end
        reg_write(REG_GLYPH_WIDTH, 8);
        send_byte(8'h0F, 1'b1, 12'h300, 12'h300);
        reg_write(REG_GLYPH_HEIGHT, 2);
        send_byte(8'hF0, 1'b0, 12'h000, 12'h000);
        quiesce();
    endtask

    task automatic test_random_glyphs(input int idle_pct, input int stall_pct, input int target);
        int          base;
        int          nbytes;
        int          pick;
        logic [11:0] ox;
        logic [11:0] oy;
        quiesce();
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        randomize_config(1'b1);
        base = drawing_bytes;
        while (drawing_bytes - base < target) begin
            if ($urandom_range(99) < 20) randomize_config(1'b0);
            nbytes = glyph_bytes();
            pick   = $urandom_range(99);
            // broken glyph, abandoned by the next start
            if (pick < 10) nbytes = $urandom_range(1, nbytes);
            ox = ($urandom_range(9) == 0) ? 12'($urandom_range(4064, 4095))
                                          : 12'($urandom_range(4095));
            oy = ($urandom_range(9) == 0) ? 12'($urandom_range(4064, 4095))
                                          : 12'($urandom_range(4095));
            for (int k = 0; k < nbytes; k++) begin
                if (k == 0) send_byte(8'($urandom_range(255)), 1'b1, ox, oy);
                else send_byte(8'($urandom_range(255)), 1'b0, 12'($urandom_range(4095)),
                               12'($urandom_range(4095)));
            end
            if (pick >= 90) begin
                repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom_range(255)), 1'b0, 12'($urandom_range(4095)),
                              12'($urandom_range(4095)));
            end
        end
        quiesce();
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        cfg_width      = 6'd16;
        cfg_height     = 6'd16;
        cfg_fore       = 24'hFFFFFF;
        cfg_back       = 24'h0;
        rows_left      = 0;
        row_num        = 0;
        cur_x          = '0;
        cur_y          = '0;
        org_x          = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        mismatches     = 0;
        bytes_sent     = 0;
        drawing_bytes  = 0;
        pixels_seen    = 0;
        reg_writes     = 0;
        cycles         = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_stray_and_wrap();
        test_degenerate_sizes();
        test_row_tails();
        test_midglyph_reconfig();
        test_random_glyphs(0, 0, 95);
        test_random_glyphs(51, 0, 95);
        test_random_glyphs(0, 51, 95);
        test_random_glyphs(29, 29, 95);

        $display("sent %0d font bytes (%0d drawing) and checked %0d pixel transactions",
                 bytes_sent, drawing_bytes, pixels_seen);
        $display("%0d register writes across four source-idle / sink-stall phases",
                 reg_writes);
        if (mismatches == 0 && pixel_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/gbpe_pkg.sv
rtl/core/gbpe_cfg_regs.sv
rtl/core/gbpe_glyph_ctrl.sv
rtl/core/gbpe_bit_serializer.sv
rtl/core/glyph_bitmap_pixel_expander.sv
tb/sv/glyph_bitmap_pixel_expander_tb.sv
